>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clock, muted while reset is high.
`define STI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising edge of clock, reset included.
`define STI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> hdl/sti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

   localparam int REQ_W    = 2;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] STS_DELETED  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_ABSENT   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } sti_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_INS  = 5'b00010,
      S_PUT  = 5'b00100,
      S_SCAN = 5'b01000,
      S_FIN  = 5'b10000
   } sti_state_type;

endpackage

`default_nettype wire

>>> hdl/sorted_table_insert_delete_search.sv
// Sorted table of signed 32-bit values, held in one memory with a registered read.
// A full-table insert, an empty table or an unused code is answered without reading the
// memory; otherwise the entries are read in turn, with one more step (S_PUT) for an insert
// at the head. One request at a time: the next is accepted only after the result leaves
// the controller; the linear walk, one entry per cycle, sets the rate.
// Reset (synchronous, active high) empties the table at once; stored values need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_insert_delete_search
   import sti_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [2:0] status, [7:3] count
);

   localparam int IW = $clog2(CAPACITY);

   logic                    done_valid;
   logic                    slot_free;
   sti_rsp_type             done_rsp;
   logic                    mem_rd_en;
   logic [IW-1:0]           mem_rd_addr;
   logic signed [VAL_W-1:0] mem_rd_data;
   logic                    mem_wr_en;
   logic [IW-1:0]           mem_wr_addr;
   logic signed [VAL_W-1:0] mem_wr_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   sti_rsp_type             rsp_data_ff, rsp_data_in;

   sti_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_type    (req_tuser),
      .req_value   ($signed(req_tdata)),
      .done_valid  (done_valid),
      .done_ready  (slot_free),
      .done_rsp    (done_rsp),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   sti_mem #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // output register: load when empty or when the held result transfers
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = done_valid;
         if (done_valid) begin
            rsp_data_in = done_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.count, rsp_data_ff.status};

endmodule

`default_nettype wire

>>> hdl/sti_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module sti_mem
   import sti_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output logic signed [VAL_W-1:0]      rd_data,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic signed [VAL_W-1:0] wr_data
);

   logic signed [VAL_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/sti_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sti_ctrl
   import sti_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [REQ_W-1:0]                req_type,
   input  wire logic signed [VAL_W-1:0]         req_value,
   output logic                                 done_valid,
   input  wire logic                            done_ready,
   output sti_rsp_type                          done_rsp,
   output logic                                 mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]          mem_rd_addr,
   input  wire logic signed [VAL_W-1:0]         mem_rd_data,
   output logic                                 mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]          mem_wr_addr,
   output logic signed [VAL_W-1:0]              mem_wr_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   sti_state_type           state_ff, state_in;
   logic [CW-1:0]           held_ff, held_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic                    found_ff, found_in;
   logic [REQ_W-1:0]        op_ff, op_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic [IW-1:0]           idx_up;
   logic [IW-1:0]           idx_dn;
   logic                    last_entry;
   logic                    advance;

   assign idx_up     = IW'(idx_ff + 1'b1);
   assign idx_dn     = IW'(idx_ff - 1'b1);
   assign last_entry = (CW'(idx_ff) + CW'(1)) == held_ff;

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_FIN);
   assign done_rsp   = '{status: status_ff, count: COUNT_W'(held_ff)};

   always_comb begin
      state_in    = state_ff;
      held_in     = held_ff;
      idx_in      = idx_ff;
      found_in    = found_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      advance     = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_up;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_up;
      mem_wr_data = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_value;
               op_in    = req_type;
               found_in = 1'b0;
               case (req_type)
                  REQ_INSERT: begin
                     if (held_ff == FULL_COUNT) begin
                        status_in = STS_FULL;
                        state_in  = S_FIN;
                     end else if (held_ff == '0) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                        mem_wr_data = req_value;
                        held_in     = CW'(1);
                        status_in   = STS_INSERTED;
                        state_in    = S_FIN;
                     end else begin
                        // walk down from the top entry, shifting as we go
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IW'(held_ff - 1'b1);
                        idx_in      = IW'(held_ff - 1'b1);
                        state_in    = S_INS;
                     end
                  end
                  REQ_DELETE, REQ_SEARCH: begin
                     if (held_ff == '0) begin
                        status_in = STS_ABSENT;
                        state_in  = S_FIN;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = STS_ABSENT;
                     state_in  = S_FIN;
                  end
               endcase
            end
         end

         S_INS: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_up;
            if (mem_rd_data >= key_ff) begin
               mem_wr_data = mem_rd_data;
               if (idx_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = idx_dn;
                  idx_in      = idx_dn;
               end
            end else begin
               mem_wr_data = key_ff;
               held_in     = CW'(held_ff + 1'b1);
               status_in   = STS_INSERTED;
               state_in    = S_FIN;
            end
         end

         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = key_ff;
            held_in     = CW'(held_ff + 1'b1);
            status_in   = STS_INSERTED;
            state_in    = S_FIN;
         end

         S_SCAN: begin
            if (op_ff == REQ_DELETE) begin
               if (found_ff || (mem_rd_data == key_ff)) begin
                  if (found_ff) begin
                     // close the gap left by the removed entry
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = idx_dn;
                     mem_wr_data = mem_rd_data;
                  end
                  found_in = 1'b1;
                  if (last_entry) begin
                     held_in   = CW'(held_ff - 1'b1);
                     status_in = STS_DELETED;
                     state_in  = S_FIN;
                  end else begin
                     advance = 1'b1;
                  end
               end else if ((mem_rd_data > key_ff) || last_entry) begin
                  status_in = STS_ABSENT;
                  state_in  = S_FIN;
               end else begin
                  advance = 1'b1;
               end
            end else begin
               if (mem_rd_data == key_ff) begin
                  status_in = STS_FOUND;
                  state_in  = S_FIN;
               end else if ((mem_rd_data > key_ff) || last_entry) begin
                  status_in = STS_ABSENT;
                  state_in  = S_FIN;
               end else begin
                  advance = 1'b1;
               end
            end
            if (advance) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_up;
               idx_in      = idx_up;
            end
         end

         S_FIN: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      status_ff <= status_in;
   end

   `STI_ASSERT(a_held_bound, held_ff <= FULL_COUNT, "entry count exceeds capacity")
   `STI_ASSERT(a_held_step, ##1 ((held_ff == $past(held_ff)) || (held_ff == CW'($past(held_ff) + 1'b1)) || (held_ff == CW'($past(held_ff) - 1'b1))), "entry count moved by more than one")
   `STI_ASSERT(a_search_no_write, (state_ff == S_SCAN && op_ff == REQ_SEARCH) |-> !mem_wr_en, "search modified the table")
   `STI_ASSERT(a_fin_release, (done_valid && done_ready) |=> req_ready, "result handed off but request side still blocked")

endmodule

`default_nettype wire

>>> tb/sv/sorted_table_insert_delete_search_tb.sv
`timescale 1ns / 1ps

module sorted_table_insert_delete_search_tb;
   import sti_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 165;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 80;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // Shadow of the sorted table plus the replies it predicts, oldest first.
   class table_shadow;
      logic signed [VAL_W-1:0] values[$];
      sti_rsp_type             pending_replies[$];
      int                      errors;
      int                      status_seen[5];

      function void note_request(logic [REQ_W-1:0] kind, logic signed [VAL_W-1:0] value);
         sti_rsp_type reply;
         int          pos;
         reply.status = STS_ABSENT;
         pos = 0;
         // lower bound: first entry not below value
         while (pos < values.size() && values[pos] < value)
            pos++;
         case (kind)
            REQ_INSERT: begin
               if (values.size() >= TABLE_DEPTH) begin
                  reply.status = STS_FULL;
               end else begin
                  values.insert(pos, value);
                  reply.status = STS_INSERTED;
               end
            end
            REQ_DELETE: begin
               if (pos < values.size() && values[pos] == value) begin
                  values.delete(pos);
                  reply.status = STS_DELETED;
               end
            end
            REQ_SEARCH: begin
               if (pos < values.size() && values[pos] == value)
                  reply.status = STS_FOUND;
            end
            default: ;
         endcase
         reply.count = COUNT_W'(values.size());
         pending_replies.push_back(reply);
      endfunction

      function void check_reply(logic [7:0] data);
         sti_rsp_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply, actual status %0d count %0d",
                     $time, data[2:0], data[7:3]);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            if (want.status <= STS_FULL)
               status_seen[want.status]++;
            if (data[2:0] !== want.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want.status, data[2:0]);
               errors++;
            end
            if (data[7:3] !== want.count) begin
               $display("%0t: count mismatch, expected %0d actual %0d",
                        $time, want.count, data[7:3]);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   table_shadow sb = new();
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_left;
   int          quiet_cycles;
   int          sent_items;

   sorted_table_insert_delete_search #(
      .CAPACITY(TABLE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one request and hold it until the transfer; valid stays high between back-to-back items.
   task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(kind, value);
      sent_items++;
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (sb.pending_replies.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45)
         return VAL_W'(int'($urandom_range(16)) - 8);
      if (roll < 70 && sb.values.size() != 0)
         return sb.values[$urandom_range(sb.values.size() - 1)];
      if (roll < 80) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h8000_0001;
            2: return 32'h7FFF_FFFE;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // Insert-heavy phases fill the table up to full, delete-heavy ones drain it.
   function automatic logic [REQ_W-1:0] pick_kind(input bit fill);
      int roll;
      roll = $urandom_range(99);
      if (roll < (fill ? 55 : 20))
         return REQ_INSERT;
      if (roll < (fill ? 75 : 65))
         return REQ_DELETE;
      if (roll < 97)
         return REQ_SEARCH;
      return REQ_UNUSED;
   endfunction

   // Receiver: check on each transfer, then pick readiness for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_reply(rsp_tdata);
         if (hold_off_left > 0) begin
            rsp_tready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d replies outstanding",
                  $time, quiet_cycles, sb.pending_replies.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int idle_mode;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_left  = 0;
      quiet_cycles   = 0;
      sent_items     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, duplicates, head delete, misses, full table
      send_req(REQ_SEARCH, 32'h0000_0005);
      send_req(REQ_DELETE, 32'h0000_0005);
      send_req(REQ_INSERT, 32'h7FFF_FFFF);
      send_req(REQ_INSERT, 32'h8000_0000);
      send_req(REQ_INSERT, 32'h0000_0000);
      send_req(REQ_INSERT, 32'h0000_0000);
      send_req(REQ_SEARCH, 32'h8000_0000);
      send_req(REQ_SEARCH, 32'h0000_0001);
      send_req(REQ_DELETE, 32'h8000_0000);
      send_req(REQ_DELETE, 32'h0000_0000);
      send_req(REQ_SEARCH, 32'h0000_0000);
      send_req(REQ_DELETE, 32'hFFFF_FFFF);
      send_req(REQ_UNUSED, 32'hFFFF_FFFF);
      while (sb.values.size() < TABLE_DEPTH)
         send_req(REQ_INSERT, $urandom);
      send_req(REQ_INSERT, 32'h0000_0001);
      send_req(REQ_SEARCH, 32'h7FFF_FFFF);
      send_req(REQ_DELETE, 32'h7FFF_FFFF);
      drain_replies();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_mode = phase / 2;
         send_idle_pct  = (idle_mode == 1) ? 57 : (idle_mode == 3) ? 31 : 0;
         recv_stall_pct = (idle_mode == 2) ? 57 : (idle_mode == 3) ? 31 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold the receiver off while requests keep coming
            if (phase == 0 && n == 40)
               hold_off_left = LONG_HOLD;
            send_req(pick_kind(phase % 2 == 0), pick_value());
         end
         drain_replies();
      end

      repeat (TABLE_DEPTH + 8) @(posedge clock);
      $display("Sent %0d requests over empty, partly filled and full tables with mixed stalls.",
               sent_items);
      $display("Replies: %0d inserted, %0d deleted, %0d found, %0d absent, %0d full.",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4]);
      if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
